[rtl/ccwc_pkg.sv]
// Package for the coin change way counter.
// Holds field widths, the denomination list, sequencer states and the status struct.
// No dependencies.
`timescale 1ns / 1ps

package ccwc_pkg;

	// Field and datapath widths
	localparam int AMT_W          = 15;   // amount_cents
	localparam int CNT_W          = 63;   // way_count
	localparam int WORD_W         = 64;   // table entry
	localparam int IDX_W          = 17;   // internal index, covers any amount up to 65535
	localparam int COIN_W         = 14;   // largest denomination is 10000
	localparam int COIN_KINDS     = 11;
	localparam int KIDX_W         = 4;    // holds 0..COIN_KINDS
	localparam int MIN_AMOUNT     = 5;
	localparam int MAX_AMOUNT_DEF = 32767;

	// Denominations, largest first, in cents
	function automatic logic [COIN_W-1:0] coin_value(input logic [KIDX_W-1:0] k);
		logic [COIN_W-1:0] v;
		unique case (k)
			4'd0:    v = 14'd10000;
			4'd1:    v = 14'd5000;
			4'd2:    v = 14'd2000;
			4'd3:    v = 14'd1000;
			4'd4:    v = 14'd500;
			4'd5:    v = 14'd200;
			4'd6:    v = 14'd100;
			4'd7:    v = 14'd50;
			4'd8:    v = 14'd20;
			4'd9:    v = 14'd10;
			4'd10:   v = 14'd5;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PASS,
		ST_SWEEP,
		ST_READ,
		ST_HOLD,
		ST_DONE
	} ccwc_state_t;

	// Sequencer status towards the top level
	typedef struct packed {
		logic busy;
		logic res_valid;
	} ccwc_stat_t;

endpackage

[rtl/ccwc_table_ram.sv]
// Ways table memory: one write port, two registered read ports.
// Depends on ccwc_pkg for the word width.
`timescale 1ns / 1ps

module ccwc_table_ram #(
	parameter int DEPTH  = ccwc_pkg::MAX_AMOUNT_DEF + 1,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ADDR_W-1:0]           waddr,
	input  logic [ccwc_pkg::WORD_W-1:0] wdata,
	input  logic [ADDR_W-1:0]           raddr_a,
	input  logic [ADDR_W-1:0]           raddr_b,
	output logic [ccwc_pkg::WORD_W-1:0] rdata_a,
	output logic [ccwc_pkg::WORD_W-1:0] rdata_b
);
	import ccwc_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read ports, old data on a same-edge collision
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[rtl/ccwc_seq.sv]
// Sequencer and shared adder: for a valid amount, clears the table, runs one sweep per
// denomination not above the amount, then reads back its entry. Depends on ccwc_pkg.
`timescale 1ns / 1ps

module ccwc_seq #(
	parameter int MAX_AMOUNT = ccwc_pkg::MAX_AMOUNT_DEF,
	parameter int ADDR_W     = $clog2(MAX_AMOUNT + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// query side
	input  logic                        in_valid,
	input  logic [ccwc_pkg::AMT_W-1:0]  in_amount,
	output logic                        in_ready,
	// result side
	input  logic                        res_ready,
	output ccwc_pkg::ccwc_stat_t        stat,
	output logic [ccwc_pkg::CNT_W-1:0]  res_count,
	// table port
	output logic                        ram_we,
	output logic [ADDR_W-1:0]           ram_waddr,
	output logic [ccwc_pkg::WORD_W-1:0] ram_wdata,
	output logic [ADDR_W-1:0]           ram_raddr_a,
	output logic [ADDR_W-1:0]           ram_raddr_b,
	input  logic [ccwc_pkg::WORD_W-1:0] ram_rdata_a,
	input  logic [ccwc_pkg::WORD_W-1:0] ram_rdata_b
);
	import ccwc_pkg::*;

	ccwc_state_t       state_q, state_d;
	logic [IDX_W-1:0]  amt_q;
	logic [IDX_W-1:0]  j_q;
	logic [KIDX_W-1:0] k_q;
	logic [CNT_W-1:0]  count_q;
	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic [IDX_W-1:0]  in_amt_ext;
	logic [IDX_W-1:0]  coin_ext;
	logic              amt_bad;
	logic              j_last;
	logic              k_end;

	assign in_amt_ext = IDX_W'(in_amount);
	assign coin_ext   = IDX_W'(coin_value(k_q));
	assign amt_bad    = (in_amt_ext < IDX_W'(MIN_AMOUNT)) ||
	                    (in_amt_ext > IDX_W'(MAX_AMOUNT));
	assign j_last     = (j_q == amt_q);
	assign k_end      = (k_q == KIDX_W'(COIN_KINDS));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		stat.busy      = (state_q != ST_IDLE);
		stat.res_valid = (state_q == ST_DONE);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = amt_bad ? ST_DONE : ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (j_last) begin
					state_d = ST_PASS;
				end
			end
			ST_PASS: begin
				// also the bubble that lets the last sweep write land
				if (k_end) begin
					state_d = ST_READ;
				end else if (coin_ext <= amt_q) begin
					state_d = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (j_last) begin
					state_d = ST_PASS;
				end
			end
			ST_READ: state_d = ST_HOLD;
			ST_HOLD: state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Index and coin counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			k_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: j_q <= '0;
				ST_CLEAR: begin
					j_q <= j_q + 1'b1;
					if (j_last) begin
						k_q <= '0;
					end
				end
				ST_PASS: begin
					if (!k_end) begin
						if (coin_ext <= amt_q) begin
							j_q <= coin_ext;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					j_q <= j_q + 1'b1;
					if (j_last) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Query payload and result capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			amt_q   <= in_amt_ext;
			count_q <= '0;
		end else if (state_q == ST_HOLD) begin
			count_q <= ram_rdata_a[CNT_W-1:0];
		end
	end

	// Sweep write-back stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == ST_SWEEP);
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= ADDR_W'(j_q);
	end

	// Table port: clear writes, or ways[j] + ways[j - coin] in the cycle after the read
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = ADDR_W'(j_q);
			ram_wdata = (j_q == '0) ? WORD_W'(1) : '0;
		end else begin
			ram_we    = wr_pend_s1;
			ram_waddr = wr_addr_s1;
			ram_wdata = ram_rdata_a + ram_rdata_b;
		end
		ram_raddr_a = (state_q == ST_READ) ? ADDR_W'(amt_q) : ADDR_W'(j_q);
		ram_raddr_b = ADDR_W'(j_q - coin_ext);
	end

	assign res_count = count_q;

endmodule

[rtl/coin_change_way_counter.sv]
// For amount A: clears entries 0..A, then sweeps entries c..A for each coin c <= A,
// one table update per cycle on the shared adder, then reads back entry A.
// Amounts below 5 or above MAX_AMOUNT skip the table and answer zero. One query at a time.
// Reset (arst_n, asynchronous, active low) clears the sequencer and the output valid;
// the ways table is not cleared, each query rebuilds the part it uses.
// Top level of the coin change way counter; instantiates ccwc_seq and ccwc_table_ram.
`timescale 1ns / 1ps

module coin_change_way_counter #(
	parameter int MAX_AMOUNT = ccwc_pkg::MAX_AMOUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [14:0] amount_cents, [15] zero
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata     // [62:0] way_count, [63] zero
);
	import ccwc_pkg::*;

	localparam int ADDR_W = $clog2(MAX_AMOUNT + 1);

	ccwc_stat_t        stat;
	logic [CNT_W-1:0]  res_count;
	logic              res_ready;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr_a;
	logic [ADDR_W-1:0] ram_raddr_b;
	logic [WORD_W-1:0] ram_rdata_a;
	logic [WORD_W-1:0] ram_rdata_b;
	logic              m_tvalid_q;
	logic [CNT_W-1:0]  count_q;

	ccwc_seq #(
		.MAX_AMOUNT (MAX_AMOUNT),
		.ADDR_W     (ADDR_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_amount   (s_tdata[AMT_W-1:0]),
		.in_ready    (s_tready),
		.res_ready   (res_ready),
		.stat        (stat),
		.res_count   (res_count),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr_a (ram_raddr_a),
		.ram_raddr_b (ram_raddr_b),
		.ram_rdata_a (ram_rdata_a),
		.ram_rdata_b (ram_rdata_b)
	);

	ccwc_table_ram #(
		.DEPTH  (MAX_AMOUNT + 1),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (ram_rdata_a),
		.rdata_b (ram_rdata_b)
	);

	// Output register: load when empty or being drained
	assign res_ready = stat.res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			count_q <= res_count;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, count_q};

	// Checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> stat.busy)
		else $error("sequencer not busy after an input transaction");

	a_no_accept_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.res_valid)
		else $error("input taken while a result is pending");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready |=> m_tvalid && !stat.res_valid)
		else $error("result handed over but output not valid");

	a_rise_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(res_ready))
		else $error("output valid without a finished result");

endmodule
